// ===== design/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CHAR_W       = 8;
    localparam int ATTR_W       = 8;
    localparam int IDX_W        = 11;
    localparam int CELL_W       = 16;
    localparam int CURSOR_ROW_W = 5;
    localparam int CURSOR_COL_W = 7;
    localparam int OFFSET_W     = 11;

    localparam int QUEUE_DEPTH  = 2;

    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [2:0] {
        OP_PRINT     = 3'd0,
        OP_NEWLINE   = 3'd1,
        OP_BACKSPACE = 3'd2,
        OP_READ      = 3'd3,
        OP_READ_NONE = 3'd4
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
    } q_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== design/text_console_writer_core.sv =====
// Top level of the text console writer: front end, item queue, back end.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  input     | start / busy         | req_type, char_code, cell_index
//  result    | done (1-cycle strobe)| cursor_row, cursor_col, cursor_offset,
//            |                      | cell_value, scrolled
//  config    | cfg_we               | cfg_wdata (text attribute)
//
// Each item passes through four back-end steps (dequeue and cursor update, address
// map, memory access, result load); done is strobed the cycle after the result load.
// An item that scrolls adds a step before the result load that blanks the new bottom row.
// After reset all ROWS*COLUMNS cells of the screen memory are cleared with busy high.
// The 2-entry queue takes up to two items ahead; busy rises when it is full.
// Results cannot be held off: each one is valid for the single done cycle.
module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
    input  logic [tcw_pkg::IDX_W-1:0]        cell_index,
    output logic                             done,
    output logic [tcw_pkg::CURSOR_ROW_W-1:0] cursor_row,
    output logic [tcw_pkg::CURSOR_COL_W-1:0] cursor_col,
    output logic [tcw_pkg::OFFSET_W-1:0]     cursor_offset,
    output logic [tcw_pkg::CELL_W-1:0]       cell_value,
    output logic                             scrolled,
    input  logic                             cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]       cfg_wdata
);
    import tcw_pkg::*;

    q_status_t q_status;
    q_item_t   push_item;
    q_item_t   head;
    logic      push;
    logic      pop;
    logic      clearing;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .char_code  (char_code),
        .cell_index (cell_index),
        .q_status   (q_status),
        .clearing   (clearing),
        .push       (push),
        .item       (push_item)
    );

    tcw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .clearing      (clearing),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .cursor_row    (cursor_row),
        .cursor_col    (cursor_col),
        .cursor_offset (cursor_offset),
        .cell_value    (cell_value),
        .scrolled      (scrolled)
    );

endmodule

// ===== design/tcw_front.sv =====
// Front end: input handshake and classification of each item.
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                        start,
    output logic                        busy,
    input  logic                        req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
    input  logic [tcw_pkg::IDX_W-1:0]   cell_index,
    input  tcw_pkg::q_status_t          q_status,
    input  logic                        clearing,
    output logic                        push,
    output tcw_pkg::q_item_t            item
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int LIN_W      = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

    logic in_range;

    assign busy     = q_status.full | clearing;
    assign push     = start & ~busy;
    assign in_range = LIN_W'(cell_index) < LIN_W'(CELL_COUNT);

    always_comb
    begin
        item.ch  = char_code;
        item.idx = cell_index;
        if (req_type == REQ_READ)
        begin
            item.op = in_range ? OP_READ : OP_READ_NONE;
        end
        else if (char_code == CH_NEWLINE)
        begin
            item.op = OP_NEWLINE;
        end
        else if (char_code == CH_BACKSPACE)
        begin
            item.op = OP_BACKSPACE;
        end
        else
        begin
            item.op = OP_PRINT;
        end
    end

endmodule

// ===== design/tcw_queue.sv =====
// Short item queue between front and back end.
module tcw_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tcw_pkg::q_item_t   push_item,
    input  logic               pop,
    output tcw_pkg::q_item_t   head,
    output tcw_pkg::q_status_t q_status
);
    import tcw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_item_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head           = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/tcw_back.sv =====
// Back end: cursor update, screen memory as a row ring, scroll and results.
module tcw_back #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tcw_pkg::q_item_t                 head,
    input  tcw_pkg::q_status_t               q_status,
    output logic                             pop,
    output logic                             clearing,
    input  logic                             cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]       cfg_wdata,
    output logic                             done,
    output logic [tcw_pkg::CURSOR_ROW_W-1:0] cursor_row,
    output logic [tcw_pkg::CURSOR_COL_W-1:0] cursor_col,
    output logic [tcw_pkg::OFFSET_W-1:0]     cursor_offset,
    output logic [tcw_pkg::CELL_W-1:0]       cell_value,
    output logic                             scrolled
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int LIN_W      = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] SCR_LAST  = ADDR_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] BASE_LAST = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
    localparam logic [CELL_W-1:0] CLEAR_CELL = {ATTR_RESET, CH_BLANK};

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_MAP    = 6'b000100,
        S_ACCESS = 6'b001000,
        S_SCROLL = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] base_reg, base_next;   // physical start of logical row 0
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic              scroll_pend_reg, scroll_pend_next;
    logic              wr_pend_reg, wr_pend_next;
    logic              done_reg, done_next;

    op_t                      op_reg;
    logic [CELL_W-1:0]        wdata_reg;
    logic [LIN_W-1:0]         lin_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic [LIN_W-1:0]         offset_reg;
    logic [CELL_W-1:0]        rd_data_reg;
    logic [CURSOR_ROW_W-1:0]  orow_reg;
    logic [CURSOR_COL_W-1:0]  ocol_reg;
    logic [OFFSET_W-1:0]      ooff_reg;
    logic [CELL_W-1:0]        ocell_reg;
    logic                     oscr_reg;

    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;

    logic [ROW_W-1:0]  calc_row, trow;
    logic [COL_W-1:0]  calc_col, tcol;
    logic              calc_wr, calc_scroll, wrap_row;
    logic [LIN_W-1:0]  calc_lin;
    logic [ADDR_W:0]   phys_sum, phys_wrap;
    logic [ADDR_W-1:0] phys;
    logic [LIN_W-1:0]  cur_offset;

    logic [ROW_W+CURSOR_ROW_W-1:0] row_wide;
    logic [COL_W+CURSOR_COL_W-1:0] col_wide;
    logic [LIN_W+OFFSET_W-1:0]     off_wide;

    // Cursor move and target cell for the item at the head of the queue.
    always_comb
    begin
        calc_row    = row_reg;
        calc_col    = col_reg;
        trow        = row_reg;
        tcol        = col_reg;
        calc_wr     = 1'b0;
        calc_scroll = 1'b0;
        wrap_row    = 1'b0;
        case (head.op)
            OP_NEWLINE:
            begin
                calc_col = '0;
                wrap_row = 1'b1;
            end
            OP_BACKSPACE:
            begin
                calc_wr = 1'b1;
                if (col_reg != '0)
                begin
                    calc_col = col_reg - 1'b1;
                end
                else if (row_reg != '0)
                begin
                    calc_row = row_reg - 1'b1;
                    calc_col = COL_LAST;
                end
                trow = calc_row;
                tcol = calc_col;
            end
            OP_PRINT:
            begin
                calc_wr = 1'b1;
                if (col_reg == COL_LAST)
                begin
                    calc_col = '0;
                    wrap_row = 1'b1;
                end
                else
                begin
                    calc_col = col_reg + 1'b1;
                end
            end
            default:
            begin
                calc_wr = 1'b0;
            end
        endcase
        if (wrap_row)
        begin
            if (row_reg == ROW_LAST)
            begin
                calc_scroll = 1'b1;
            end
            else
            begin
                calc_row = row_reg + 1'b1;
            end
        end
        if (head.op == OP_READ || head.op == OP_READ_NONE)
        begin
            calc_lin = LIN_W'(head.idx);
        end
        else
        begin
            calc_lin = LIN_W'(trow) * LIN_W'(COLUMNS) + LIN_W'(tcol);
        end
    end

    // Logical to physical address in the row ring.
    assign phys_sum   = {1'b0, lin_reg[ADDR_W-1:0]} + {1'b0, base_reg};
    assign phys_wrap  = phys_sum - (ADDR_W+1)'(CELL_COUNT);
    assign phys       = (phys_sum >= (ADDR_W+1)'(CELL_COUNT)) ? phys_wrap[ADDR_W-1:0]
                                                              : phys_sum[ADDR_W-1:0];
    assign cur_offset = LIN_W'(row_reg) * LIN_W'(COLUMNS) + LIN_W'(col_reg);

    always_comb
    begin
        state_next       = state_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        base_next        = base_reg;
        cnt_next         = cnt_reg;
        scroll_pend_next = scroll_pend_reg;
        wr_pend_next     = wr_pend_reg;
        attr_next        = cfg_we ? cfg_wdata : attr_reg;
        done_next        = 1'b0;
        pop              = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = addr_reg;
        mem_wdata        = wdata_reg;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = CLEAR_CELL;
                if (cnt_reg == CELL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop              = 1'b1;
                    row_next         = calc_row;
                    col_next         = calc_col;
                    scroll_pend_next = calc_scroll;
                    wr_pend_next     = calc_wr;
                    state_next       = S_MAP;
                end
            end
            S_MAP:
            begin
                state_next = S_ACCESS;
            end
            S_ACCESS:
            begin
                mem_we     = wr_pend_reg;
                cnt_next   = '0;
                state_next = scroll_pend_reg ? S_SCROLL : S_DONE;
            end
            S_SCROLL:
            begin
                // old top row becomes the new bottom row: blank it, then rotate
                mem_we    = 1'b1;
                mem_waddr = base_reg + cnt_reg;
                mem_wdata = {attr_reg, CH_BLANK};
                if (cnt_reg == SCR_LAST)
                begin
                    cnt_next   = '0;
                    base_next  = (base_reg == BASE_LAST) ? '0 : base_reg + ROW_STEP;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            row_reg         <= '0;
            col_reg         <= '0;
            base_reg        <= '0;
            cnt_reg         <= '0;
            attr_reg        <= ATTR_RESET;
            scroll_pend_reg <= 1'b0;
            wr_pend_reg     <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            base_reg        <= base_next;
            cnt_reg         <= cnt_next;
            attr_reg        <= attr_next;
            scroll_pend_reg <= scroll_pend_next;
            wr_pend_reg     <= wr_pend_next;
            done_reg        <= done_next;
        end
    end

    assign row_wide = {{CURSOR_ROW_W{1'b0}}, row_reg};
    assign col_wide = {{CURSOR_COL_W{1'b0}}, col_reg};
    assign off_wide = {{OFFSET_W{1'b0}}, offset_reg};

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && !q_status.empty)
        begin
            op_reg    <= head.op;
            lin_reg   <= calc_lin;
            wdata_reg <= {attr_reg, (head.op == OP_BACKSPACE) ? CH_BLANK : head.ch};
        end
        if (state_reg == S_MAP)
        begin
            addr_reg   <= phys;
            offset_reg <= cur_offset;
        end
        if (state_reg == S_DONE)
        begin
            orow_reg  <= row_wide[CURSOR_ROW_W-1:0];
            ocol_reg  <= col_wide[CURSOR_COL_W-1:0];
            ooff_reg  <= off_wide[OFFSET_W-1:0];
            ocell_reg <= (op_reg == OP_READ) ? rd_data_reg : '0;
            oscr_reg  <= scroll_pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == S_ACCESS)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    assign clearing      = (state_reg == S_CLEAR);
    assign done          = done_reg;
    assign cursor_row    = orow_reg;
    assign cursor_col    = ocol_reg;
    assign cursor_offset = ooff_reg;
    assign cell_value    = ocell_reg;
    assign scrolled      = oscr_reg;

endmodule

// ===== design/tcw_checker.sv =====
// Port-level assertions for the text console writer, bound to the top level.
module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             busy,
    input logic                             done,
    input logic [tcw_pkg::CURSOR_ROW_W-1:0] cursor_row,
    input logic [tcw_pkg::CURSOR_COL_W-1:0] cursor_col,
    input logic [tcw_pkg::OFFSET_W-1:0]     cursor_offset,
    input logic                             scrolled
);
    import tcw_pkg::*;

    // cursor fields carry full values only when they fit the port widths
    localparam logic EXACT = (ROWS <= 32) && (COLUMNS <= 128) && (ROWS * COLUMNS <= 2048);

    // the back end walks each item through its idle, map and access states, so results never abut
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && EXACT) |-> (32'(cursor_col) < COLUMNS))
        else $error("cursor column out of range");

    a_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (done && EXACT) |->
            (cursor_offset == OFFSET_W'(32'(cursor_row) * COLUMNS + 32'(cursor_col))))
        else $error("cursor offset does not match row and column");

    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (done && scrolled && EXACT) |-> (32'(cursor_row) == ROWS - 1))
        else $error("scroll without cursor on last row");

    // the clearing pass holds off items right after reset
    a_busy_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> busy)
        else $error("busy low at reset release");

endmodule

bind text_console_writer_core tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .busy          (busy),
    .done          (done),
    .cursor_row    (cursor_row),
    .cursor_col    (cursor_col),
    .cursor_offset (cursor_offset),
    .scrolled      (scrolled)
);

// ===== bench/tb_text_console_writer_core.sv =====
// Self-checking bench for text_console_writer_core: queued driver, monitor, cell-grid predictor.
module tb_text_console_writer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLUMNS = DEF_COLUMNS;
    localparam int ROWS    = DEF_ROWS;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int SETTLE  = COLUMNS + 16;   // quiet cycles before a sync step and at the end
    localparam int MAX_GAP = 14;

    typedef enum logic [1:0] {
        PK_CHAR,   // one put or read item
        PK_ATTR,   // attribute write once the block is idle
        PK_HOLD    // stop sending until every result is back
    } pend_kind_t;

    typedef struct {
        pend_kind_t          kind;
        logic                req;
        logic [CHAR_W-1:0]   ch;
        logic [IDX_W-1:0]    idx;
        logic [ATTR_W-1:0]   attr;
        int                  gap;
    } pend_t;

    typedef struct packed {
        logic [CURSOR_ROW_W-1:0] row;
        logic [CURSOR_COL_W-1:0] col;
        logic [OFFSET_W-1:0]     off;
        logic [CELL_W-1:0]       cval;
        logic                    scr;
    } console_res_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    req_type = REQ_PUT;
    logic [CHAR_W-1:0]       char_code = '0;
    logic [IDX_W-1:0]        cell_index = '0;
    logic                    done;
    logic [CURSOR_ROW_W-1:0] cursor_row;
    logic [CURSOR_COL_W-1:0] cursor_col;
    logic [OFFSET_W-1:0]     cursor_offset;
    logic [CELL_W-1:0]       cell_value;
    logic                    scrolled;
    logic                    cfg_we = 1'b0;
    logic [ATTR_W-1:0]       cfg_wdata = '0;

    pend_t        pending[$];
    console_res_t res_q[$];

    logic [CELL_W-1:0] shadow_screen [CELLS];
    logic [ATTR_W-1:0] shadow_attr;
    int                shadow_row;
    int                shadow_col;

    logic item_taken = 1'b0;
    int   gap_left = 0;
    int   settle = 0;
    bit   no_gaps = 1'b0;
    int   errors = 0;
    int   n_put = 0, n_read = 0, n_oor = 0, n_scroll = 0, n_cfg = 0, n_res = 0;

    text_console_writer_core #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .char_code    (char_code),
        .cell_index   (cell_index),
        .done         (done),
        .cursor_row   (cursor_row),
        .cursor_col   (cursor_col),
        .cursor_offset(cursor_offset),
        .cell_value   (cell_value),
        .scrolled     (scrolled),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // cursor to next row; past the bottom the grid moves up one line
    function automatic logic advance_row();
        if (shadow_row + 1 < ROWS)
        begin
            shadow_row++;
            return 1'b0;
        end
        for (int i = 0; i < CELLS - COLUMNS; i++)
            shadow_screen[i] = shadow_screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            shadow_screen[i] = {shadow_attr, CH_BLANK};
        n_scroll++;
        return 1'b1;
    endfunction

    function automatic console_res_t console_step(input logic req,
                                                  input logic [CHAR_W-1:0] ch,
                                                  input logic [IDX_W-1:0] idx);
        console_res_t r;
        int off;
        r = '0;
        if (req == REQ_READ)
        begin
            n_read++;
            if (idx < CELLS)
                r.cval = shadow_screen[idx];
            else
                n_oor++;
        end
        else
        begin
            n_put++;
            if (ch == CH_NEWLINE)
            begin
                shadow_col = 0;
                r.scr = advance_row();
            end
            else if (ch == CH_BACKSPACE)
            begin
                if (shadow_col > 0)
                    shadow_col--;
                else if (shadow_row > 0)
                begin
                    shadow_row--;
                    shadow_col = COLUMNS - 1;
                end
                shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_attr, CH_BLANK};
            end
            else
            begin
                shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_attr, ch};
                shadow_col++;
                if (shadow_col >= COLUMNS)
                begin
                    shadow_col = 0;
                    r.scr = advance_row();
                end
            end
        end
        off = shadow_row * COLUMNS + shadow_col;
        r.row = CURSOR_ROW_W'(shadow_row);
        r.col = CURSOR_COL_W'(shadow_col);
        r.off = OFFSET_W'(off);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d (0x%0h), got %0d (0x%0h)",
                   name, want, want, got, got);
            errors++;
        end
    endtask

    task automatic add_item(input logic req, input logic [CHAR_W-1:0] ch,
                            input logic [IDX_W-1:0] idx);
        pend_t p;
        p.kind = PK_CHAR;
        p.req  = req;
        p.ch   = ch;
        p.idx  = idx;
        p.attr = '0;
        p.gap  = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        pending.push_back(p);
    endtask

    task automatic add_sync(input pend_kind_t kind, input logic [ATTR_W-1:0] attr);
        pend_t p;
        p.kind = kind;
        p.req  = REQ_PUT;
        p.ch   = '0;
        p.idx  = '0;
        p.attr = attr;
        p.gap  = 0;
        pending.push_back(p);
    endtask

    function automatic logic [CHAR_W-1:0] rand_put_char();
        if ($urandom_range(0, 9) == 0)
            return CHAR_W'($urandom_range(0, 255));
        return CHAR_W'($urandom_range(32, 126));
    endfunction

    // reads lean on the bottom row, where most writing and scrolling happen
    function automatic logic [IDX_W-1:0] rand_cell_index();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return IDX_W'($urandom_range(0, CELLS - 1));
        if (sel < 70)
            return IDX_W'($urandom_range(CELLS - COLUMNS, CELLS - 1));
        if (sel < 85)
            return IDX_W'($urandom_range(CELLS, (1 << IDX_W) - 1));
        return IDX_W'($urandom_range(0, 2 * COLUMNS - 1));
    endfunction

    task automatic add_random_item();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            add_item(REQ_PUT, rand_put_char(), IDX_W'($urandom_range(0, 2047)));
        else if (sel < 62)
            add_item(REQ_PUT, CH_NEWLINE, IDX_W'($urandom_range(0, 2047)));
        else if (sel < 72)
            add_item(REQ_PUT, CH_BACKSPACE, IDX_W'($urandom_range(0, 2047)));
        else
            add_item(REQ_READ, CHAR_W'($urandom_range(0, 255)), rand_cell_index());
    endtask

    // driver: one item at a time from the pending queue, changes on the falling edge
    always @(negedge clk)
    begin : drive
        pend_t p;
        logic  nx_start;
        logic  nx_we;
        nx_start = start;
        nx_we    = 1'b0;
        if (rst_n)
        begin
            if (start && item_taken)
                nx_start = 1'b0;
            if (!nx_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending.size() > 0)
                begin
                    p = pending[0];
                    if (p.kind == PK_CHAR)
                    begin
                        void'(pending.pop_front());
                        nx_start   = 1'b1;
                        req_type   <= p.req;
                        char_code  <= p.ch;
                        cell_index <= p.idx;
                        gap_left   = p.gap;
                    end
                    else if (res_q.size() == 0 && !busy)
                    begin
                        if (settle < SETTLE)
                            settle++;
                        else
                        begin
                            settle = 0;
                            void'(pending.pop_front());
                            if (p.kind == PK_ATTR)
                            begin
                                nx_we = 1'b1;
                                cfg_wdata <= p.attr;
                            end
                        end
                    end
                    else
                        settle = 0;
                end
            end
        end
        start  <= nx_start;
        cfg_we <= nx_we;
    end

    // monitor: check results, track attribute writes, predict accepted items
    always @(posedge clk)
    begin : watch
        console_res_t want;
        if (!rst_n)
            item_taken = 1'b0;
        else
        begin
            if (done)
            begin
                n_res++;
                if (res_q.size() == 0)
                begin
                    $error("result strobe with no item outstanding");
                    errors++;
                end
                else
                begin
                    want = res_q.pop_front();
                    check_field("cursor_row", want.row, cursor_row);
                    check_field("cursor_col", want.col, cursor_col);
                    check_field("cursor_offset", want.off, cursor_offset);
                    check_field("cell_value", want.cval, cell_value);
                    check_field("scrolled", want.scr, scrolled);
                end
            end
            if (cfg_we)
            begin
                shadow_attr = cfg_wdata;
                n_cfg++;
            end
            item_taken = start && !busy;
            if (item_taken)
                res_q.push_back(console_step(req_type, char_code, cell_index));
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout: stimulus or results did not complete");
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < CELLS; i++)
            shadow_screen[i] = {ATTR_RESET, CH_BLANK};
        shadow_attr = ATTR_RESET;
        shadow_row  = 0;
        shadow_col  = 0;

        // directed: reset contents, index extremes, control bytes, wraps, attributes
        add_item(REQ_READ, 8'h00, 11'd0);
        add_item(REQ_READ, 8'h00, IDX_W'(CELLS - 1));
        add_item(REQ_READ, 8'h00, IDX_W'(CELLS));
        add_item(REQ_READ, 8'hFF, 11'h7FF);
        add_item(REQ_PUT, CH_BACKSPACE, 11'd0);        // backspace at home
        add_item(REQ_READ, 8'h00, 11'd0);
        add_item(REQ_PUT, 8'h41, 11'h7FF);             // index ignored on puts
        add_item(REQ_PUT, 8'h00, 11'd0);
        add_item(REQ_PUT, 8'hFF, 11'd0);
        add_item(REQ_PUT, 8'h0D, 11'd0);               // other control bytes print
        add_item(REQ_PUT, CH_NEWLINE, 11'd0);
        add_item(REQ_PUT, CH_BACKSPACE, 11'd0);        // wraps to end of row above
        add_item(REQ_PUT, 8'h7E, 11'd0);               // last column, wraps forward
        add_item(REQ_PUT, CH_BACKSPACE, 11'd0);
        add_item(REQ_READ, 8'h00, IDX_W'(COLUMNS - 1));
        add_item(REQ_READ, 8'h00, 11'd1);
        add_item(REQ_READ, 8'h00, 11'd3);
        add_sync(PK_ATTR, 8'h00);
        add_item(REQ_PUT, 8'h55, 11'd0);
        add_item(REQ_READ, 8'h00, IDX_W'(COLUMNS - 1));
        add_sync(PK_ATTR, 8'hFF);
        add_item(REQ_PUT, CH_BACKSPACE, 11'd0);
        add_item(REQ_READ, 8'h00, IDX_W'(COLUMNS - 1));
        add_item(REQ_READ, 8'h00, 11'd2);

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: add_sync(PK_ATTR, ATTR_W'($urandom_range(0, 255)));
                1: add_sync(PK_ATTR, 8'hFF);
                2: add_sync(PK_ATTR, ATTR_W'($urandom_range(0, 255)));
                3: add_sync(PK_ATTR, 8'h00);
                default: add_sync(PK_ATTR, ATTR_RESET);
            endcase
            no_gaps = (ph == 2);
            if (ph == 1)
            begin
                // enough newlines to reach the bottom and scroll
                for (int i = 0; i < ROWS + 1; i++)
                    add_item(REQ_PUT, CH_NEWLINE, IDX_W'($urandom_range(0, 2047)));
                add_sync(PK_HOLD, '0);
            end
            for (int i = 0; i < 62; i++)
            begin
                if (ph == 3 && i == 35)
                    add_sync(PK_HOLD, '0);
                add_random_item();
            end
            if (ph == 4)
            begin
                // a full line plus a few: wrap on the last row scrolls
                for (int i = 0; i < COLUMNS + 5; i++)
                    add_item(REQ_PUT, CHAR_W'($urandom_range(32, 126)),
                             IDX_W'($urandom_range(0, 2047)));
                for (int i = 0; i < 10; i++)
                    add_item(REQ_READ, 8'h00,
                             IDX_W'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1)));
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() > 0 || start || res_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d puts and %0d reads (%0d beyond the grid), %0d results",
                 n_put, n_read, n_oor, n_res);
        $display("screen scrolled %0d times over %0d attribute settings",
                 n_scroll, n_cfg);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
